// ----- src/tedq_pkg.sv -----
// ----------------------------------------------------------------------------
// tedq_pkg
// Shared types and constants of the tile element delay quantizer.
// ----------------------------------------------------------------------------
`default_nettype none
package tedq_pkg;

    localparam int TILE_ELEMENTS = 16;
    localparam int DELAY_STEPS   = 32;
    localparam int SEARCH_RADIUS = 2;

    localparam int TILE_W     = $clog2(TILE_ELEMENTS);
    localparam int STEP_W     = $clog2(DELAY_STEPS);
    localparam int SRCH_W     = $clog2(2 * SEARCH_RADIUS + 2);
    localparam int MEAN_SHIFT = $clog2(DELAY_STEPS);

    localparam int IDX_W   = 5;
    localparam int MM_W    = 13;
    localparam int PS_W    = 15;
    localparam int DIR_W   = 16;
    localparam int SUM_W   = 20;
    localparam int ELEM_W  = 4;
    localparam int CODE_W  = 8;
    localparam int CHOSEN_W = 5;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 24;

    localparam logic [1:0] REQ_TILE  = 2'd0;
    localparam logic [1:0] REQ_STEP  = 2'd1;
    localparam logic [1:0] REQ_POINT = 2'd2;

    localparam logic [17:0] PS_PER_MM_Q16 = 18'd218605;
    localparam logic [17:0] RECIP_500     = 18'd134218;
    localparam int          RECIP_SHIFT   = 26;
    localparam int          MAX_STEP      = 31;
    localparam logic [CODE_W-1:0] ENABLE_CODE = 8'd128;

    typedef enum logic [1:0] {
        CMD_TILE,
        CMD_STEP,
        CMD_POINT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [IDX_W-1:0]        idx;
        logic signed [MM_W-1:0]  x;
        logic signed [MM_W-1:0]  y;
        logic [PS_W-1:0]         step;
        logic signed [DIR_W-1:0] l;
        logic signed [DIR_W-1:0] m;
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_L,
        S_SQ_M,
        S_TEST,
        S_SQRT,
        S_DIV_L,
        S_DIV_M,
        S_PROD,
        S_SUM,
        S_SCALE,
        S_ROUND,
        S_DELAY,
        S_ROUGH,
        S_SEARCH,
        S_EMIT
    } back_state_t;

endpackage
`default_nettype wire

// ----- src/tedq_front.sv -----
// ----------------------------------------------------------------------------
// tedq_front
// Request intake: unpacks the input stream, classifies the request and drops
// unknown kinds and out-of-range load indexes before the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module tedq_front (
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [tedq_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic [1:0]                        s_tuser,
    input  wire logic                              q_full,
    output logic                                   q_push,
    output tedq_pkg::cmd_t                         q_cmd
);

    logic keep;

    always_comb
    begin
        q_cmd.idx  = s_tdata[4:0];
        q_cmd.x    = s_tdata[17:5];
        q_cmd.y    = s_tdata[30:18];
        q_cmd.step = s_tdata[45:31];
        q_cmd.l    = s_tdata[61:46];
        q_cmd.m    = s_tdata[77:62];
        q_cmd.kind = tedq_pkg::CMD_POINT;
        keep       = 1'b0;
        case (s_tuser)
            tedq_pkg::REQ_TILE:
            begin
                q_cmd.kind = tedq_pkg::CMD_TILE;
                keep = ({1'b0, s_tdata[4:0]} < 6'(tedq_pkg::TILE_ELEMENTS));
            end
            tedq_pkg::REQ_STEP:
            begin
                q_cmd.kind = tedq_pkg::CMD_STEP;
                keep = ({1'b0, s_tdata[4:0]} < 6'(tedq_pkg::DELAY_STEPS));
            end
            tedq_pkg::REQ_POINT:
            begin
                q_cmd.kind = tedq_pkg::CMD_POINT;
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && keep;

endmodule
`default_nettype wire

// ----- src/tedq_queue.sv -----
// ----------------------------------------------------------------------------
// tedq_queue
// Two-entry request queue between intake and execution.
// ----------------------------------------------------------------------------
`default_nettype none
module tedq_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire tedq_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output logic                valid,
    output tedq_pkg::cmd_t      head
);

    tedq_pkg::cmd_t mem_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;
    logic           do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// ----- src/tedq_back.sv -----
// ----------------------------------------------------------------------------
// tedq_back
// Execution: owns the offset and step tables, runs the normalization
// (square root and two divisions) and the per-element delay and search.
// ----------------------------------------------------------------------------
`default_nettype none
module tedq_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           q_valid,
    input  wire tedq_pkg::cmd_t                 q_cmd,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [tedq_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);

    localparam int R = tedq_pkg::SEARCH_RADIUS;

    tedq_pkg::back_state_t state_reg, state_next;

    logic signed [tedq_pkg::MM_W-1:0] tile_x_reg [tedq_pkg::TILE_ELEMENTS];
    logic signed [tedq_pkg::MM_W-1:0] tile_y_reg [tedq_pkg::TILE_ELEMENTS];
    logic [tedq_pkg::PS_W-1:0]        step_tab_reg [tedq_pkg::DELAY_STEPS];
    logic [tedq_pkg::SUM_W-1:0]       step_sum_reg;

    logic signed [16:0] l_reg, m_reg;
    logic [31:0]        sq_reg;
    logic [31:0]        sqv_reg, sqres_reg, sqbit_reg;
    logic [4:0]         cnt_reg;
    logic [30:0]        div_num_reg, div_q_reg;
    logic [15:0]        div_rem_reg;
    logic               norm_reg;

    logic [tedq_pkg::ELEM_W-1:0] elem_reg;
    logic signed [29:0] p1_reg, p2_reg;
    logic signed [30:0] psum_reg;
    logic signed [49:0] prod_reg;
    logic signed [17:0] geo_reg;
    logic signed [18:0] delay_reg;
    logic signed [9:0]  rough_reg, best_reg;
    logic [tedq_pkg::SRCH_W-1:0] srch_reg;
    logic [19:0]        bestdiff_reg;
    logic               have_reg;

    logic                                out_valid_reg;
    logic [tedq_pkg::ELEM_W-1:0]         out_elem_reg;
    logic [tedq_pkg::CHOSEN_W-1:0]       out_step_reg;
    logic                                out_norm_reg;
    logic                                out_last_reg;

    // control decode
    logic emit_fire, sq_done, div_done, srch_done, elem_done;

    // datapath helpers
    logic [32:0] sq_trial;
    logic        sq_take;
    logic [15:0] root;
    logic [16:0] div_shift;
    logic        div_take;
    logic [30:0] div_q_new;
    logic [15:0] div_rem_new;
    logic [15:0] mag_l, mag_m;
    logic signed [16:0] div_res;
    logic [49:0] pmag;
    logic [18:0] gmag;
    logic [17:0] dmag;
    logic [35:0] qprod;
    logic [9:0]  qrough;
    logic signed [9:0] offs, cand;
    logic        cand_ok;
    logic [tedq_pkg::PS_W-1:0] cand_entry;
    logic signed [19:0] cdiff;
    logic [19:0] cabs;
    logic        cand_take;
    logic [tedq_pkg::CHOSEN_W-1:0] clamped;
    logic [tedq_pkg::PS_W-1:0] mean;

    // ---------------------------------------------------------- decode
    always_comb
    begin
        q_pop     = 1'b0;
        emit_fire = 1'b0;
        case (state_reg)
            tedq_pkg::S_IDLE: q_pop = q_valid;
            tedq_pkg::S_EMIT: emit_fire = !out_valid_reg || m_tready;
            default:
            begin
                q_pop     = 1'b0;
                emit_fire = 1'b0;
            end
        endcase
    end

    assign sq_done   = (cnt_reg == 5'd0);
    assign div_done  = (cnt_reg == 5'd0);
    assign srch_done = (srch_reg == tedq_pkg::SRCH_W'(2 * R));
    assign elem_done = (elem_reg == tedq_pkg::ELEM_W'(tedq_pkg::TILE_ELEMENTS - 1));

    // ---------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tedq_pkg::S_IDLE:
                if (q_valid && q_cmd.kind == tedq_pkg::CMD_POINT)
                    state_next = tedq_pkg::S_SQ_L;
            tedq_pkg::S_SQ_L: state_next = tedq_pkg::S_SQ_M;
            tedq_pkg::S_SQ_M: state_next = tedq_pkg::S_TEST;
            tedq_pkg::S_TEST:
                state_next = (sq_reg > 32'h4000_0000) ? tedq_pkg::S_SQRT
                                                      : tedq_pkg::S_PROD;
            tedq_pkg::S_SQRT:  if (sq_done) state_next = tedq_pkg::S_DIV_L;
            tedq_pkg::S_DIV_L: if (div_done) state_next = tedq_pkg::S_DIV_M;
            tedq_pkg::S_DIV_M: if (div_done) state_next = tedq_pkg::S_PROD;
            tedq_pkg::S_PROD:  state_next = tedq_pkg::S_SUM;
            tedq_pkg::S_SUM:   state_next = tedq_pkg::S_SCALE;
            tedq_pkg::S_SCALE: state_next = tedq_pkg::S_ROUND;
            tedq_pkg::S_ROUND: state_next = tedq_pkg::S_DELAY;
            tedq_pkg::S_DELAY: state_next = tedq_pkg::S_ROUGH;
            tedq_pkg::S_ROUGH: state_next = tedq_pkg::S_SEARCH;
            tedq_pkg::S_SEARCH: if (srch_done) state_next = tedq_pkg::S_EMIT;
            tedq_pkg::S_EMIT:
                if (emit_fire)
                    state_next = elem_done ? tedq_pkg::S_IDLE : tedq_pkg::S_PROD;
            default: state_next = tedq_pkg::S_IDLE;
        endcase
    end

    // ---------------------------------------------------------- arithmetic
    always_comb
    begin
        sq_trial = {1'b0, sqres_reg} + {1'b0, sqbit_reg};
        sq_take  = ({1'b0, sqv_reg} >= sq_trial);
        root     = sqres_reg[15:0];

        div_shift   = {div_rem_reg, div_num_reg[30]};
        div_take    = (div_shift >= {1'b0, root});
        div_rem_new = div_take ? 16'(div_shift - {1'b0, root}) : div_shift[15:0];
        div_q_new   = {div_q_reg[29:0], div_take};

        mag_l = l_reg[16] ? 16'(-l_reg) : l_reg[15:0];
        mag_m = m_reg[16] ? 16'(-m_reg) : m_reg[15:0];
        div_res = $signed({1'b0, div_q_new[15:0]});

        pmag = prod_reg[49] ? 50'(-prod_reg) : 50'(prod_reg);
        gmag = 19'((pmag + 50'(64'h4000_0000)) >> 31);
        mean = tedq_pkg::PS_W'(step_sum_reg >> tedq_pkg::MEAN_SHIFT);

        dmag   = delay_reg[18] ? 18'(-delay_reg) : delay_reg[17:0];
        qprod  = 36'(dmag) * 36'(tedq_pkg::RECIP_500);
        qrough = qprod[tedq_pkg::RECIP_SHIFT +: 10];

        if (srch_reg == '0)
            offs = 10'sd0;
        else if (srch_reg <= tedq_pkg::SRCH_W'(R))
            offs = $signed(10'(srch_reg)) - 10'sd1 - 10'(R);
        else
            offs = $signed(10'(srch_reg)) - 10'(R);
        cand    = rough_reg + offs;
        cand_ok = (cand >= 10'sd0) && (cand < 10'(tedq_pkg::DELAY_STEPS));
        cand_entry = step_tab_reg[cand[tedq_pkg::STEP_W-1:0]];
        cdiff   = 20'(delay_reg) - $signed({5'b0, cand_entry});
        cabs    = cdiff[19] ? 20'(-cdiff) : 20'(cdiff);
        cand_take = cand_ok && (!have_reg || cabs < bestdiff_reg);

        if (best_reg < 10'sd0)
            clamped = '0;
        else if (best_reg > 10'(tedq_pkg::MAX_STEP))
            clamped = tedq_pkg::CHOSEN_W'(tedq_pkg::MAX_STEP);
        else
            clamped = best_reg[tedq_pkg::CHOSEN_W-1:0];
    end

    // ---------------------------------------------------------- control regs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tedq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            step_sum_reg  <= '0;
            for (int i = 0; i < tedq_pkg::TILE_ELEMENTS; i++)
            begin
                tile_x_reg[i] <= '0;
                tile_y_reg[i] <= '0;
            end
            for (int i = 0; i < tedq_pkg::DELAY_STEPS; i++)
            begin
                step_tab_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (emit_fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (q_pop && q_cmd.kind == tedq_pkg::CMD_TILE)
            begin
                tile_x_reg[q_cmd.idx[tedq_pkg::TILE_W-1:0]] <= q_cmd.x;
                tile_y_reg[q_cmd.idx[tedq_pkg::TILE_W-1:0]] <= q_cmd.y;
            end
            if (q_pop && q_cmd.kind == tedq_pkg::CMD_STEP)
            begin
                step_tab_reg[q_cmd.idx[tedq_pkg::STEP_W-1:0]] <= q_cmd.step;
                step_sum_reg <= step_sum_reg
                    - tedq_pkg::SUM_W'(step_tab_reg[q_cmd.idx[tedq_pkg::STEP_W-1:0]])
                    + tedq_pkg::SUM_W'(q_cmd.step);
            end
        end
    end

    // ---------------------------------------------------------- datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            tedq_pkg::S_IDLE:
            begin
                l_reg    <= 17'(q_cmd.l);
                m_reg    <= 17'(q_cmd.m);
                norm_reg <= 1'b0;
                elem_reg <= '0;
            end
            tedq_pkg::S_SQ_L:
                sq_reg <= 32'(l_reg * l_reg);
            tedq_pkg::S_SQ_M:
                sq_reg <= sq_reg + 32'(m_reg * m_reg);
            tedq_pkg::S_TEST:
            begin
                sqv_reg   <= sq_reg;
                sqres_reg <= '0;
                sqbit_reg <= 32'h4000_0000;
                cnt_reg   <= 5'd15;
            end
            tedq_pkg::S_SQRT:
            begin
                if (sq_take)
                begin
                    sqv_reg   <= 32'({1'b0, sqv_reg} - sq_trial);
                    sqres_reg <= (sqres_reg >> 1) + sqbit_reg;
                end
                else
                begin
                    sqres_reg <= sqres_reg >> 1;
                end
                sqbit_reg <= sqbit_reg >> 2;
                if (sq_done)
                begin
                    cnt_reg     <= 5'd30;
                    div_rem_reg <= '0;
                    div_q_reg   <= '0;
                    norm_reg    <= 1'b1;
                    // numerator of the rescale is taken from the next root value
                    if (sq_take)
                        div_num_reg <= {mag_l, 15'b0}
                            + 31'(((sqres_reg >> 1) + sqbit_reg) >> 1);
                    else
                        div_num_reg <= {mag_l, 15'b0} + 31'(sqres_reg >> 2);
                end
                else
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
            tedq_pkg::S_DIV_L, tedq_pkg::S_DIV_M:
            begin
                if (div_done)
                begin
                    div_rem_reg <= '0;
                    div_q_reg   <= '0;
                    cnt_reg     <= 5'd30;
                    div_num_reg <= {mag_m, 15'b0} + 31'(root >> 1);
                    if (state_reg == tedq_pkg::S_DIV_L)
                        l_reg <= l_reg[16] ? -div_res : div_res;
                    else
                        m_reg <= m_reg[16] ? -div_res : div_res;
                end
                else
                begin
                    div_rem_reg <= div_rem_new;
                    div_q_reg   <= div_q_new;
                    div_num_reg <= {div_num_reg[29:0], 1'b0};
                    cnt_reg     <= cnt_reg - 5'd1;
                end
            end
            tedq_pkg::S_PROD:
            begin
                p1_reg <= 30'(l_reg * tile_x_reg[elem_reg[tedq_pkg::TILE_W-1:0]]);
                p2_reg <= 30'(m_reg * tile_y_reg[elem_reg[tedq_pkg::TILE_W-1:0]]);
            end
            tedq_pkg::S_SUM:
                psum_reg <= 31'(p1_reg) + 31'(p2_reg);
            tedq_pkg::S_SCALE:
                prod_reg <= 50'(psum_reg) * $signed({1'b0, tedq_pkg::PS_PER_MM_Q16});
            tedq_pkg::S_ROUND:
                geo_reg <= prod_reg[49] ? -$signed(gmag[17:0]) : $signed(gmag[17:0]);
            tedq_pkg::S_DELAY:
                delay_reg <= 19'(geo_reg) + $signed({4'b0, mean});
            tedq_pkg::S_ROUGH:
            begin
                rough_reg <= delay_reg[18] ? -$signed(qrough) : $signed(qrough);
                best_reg  <= delay_reg[18] ? -$signed(qrough) : $signed(qrough);
                have_reg  <= 1'b0;
                srch_reg  <= '0;
            end
            tedq_pkg::S_SEARCH:
            begin
                srch_reg <= srch_reg + 1'b1;
                if (cand_take)
                begin
                    best_reg     <= cand;
                    bestdiff_reg <= cabs;
                    have_reg     <= 1'b1;
                end
            end
            tedq_pkg::S_EMIT:
                if (emit_fire)
                begin
                    out_elem_reg <= elem_reg;
                    out_step_reg <= clamped;
                    out_norm_reg <= norm_reg;
                    out_last_reg <= elem_done;
                    elem_reg     <= elem_reg + 1'b1;
                end
            default:
            begin
                elem_reg <= elem_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_step_reg,
                       tedq_pkg::CODE_W'({out_step_reg, 2'b00}) + tedq_pkg::ENABLE_CODE,
                       out_elem_reg};
    assign m_tuser  = out_norm_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

// ----- src/tile_element_delay_quantizer_unit.sv -----
// ----------------------------------------------------------------------------
// tile_element_delay_quantizer_unit
// Quantizes per-element true time delays of a tile for a pointing direction.
// ----------------------------------------------------------------------------
// Input stream s_*: tuser is the request type (tile offset load, step table
// load, pointing). Loads yield nothing; a pointing yields sixteen results on
// m_*, elements in ascending order, tlast on the final one.
// Requests pass a two-entry queue to the execution sequencer, so intake
// keeps taking requests while execution is busy, up to the queue depth.
// A load updates its table as execution pops it from the queue, which it does
// only while idle. A pointing leaves the queue, runs the norm test (S_SQ_L,
// S_SQ_M, S_TEST) and, when l,m need rescaling, a 16-step square root and two
// 31-step divisions in one shared divider; then per element one multiply
// chain of 6 stages, a table search through one table read port and an emit
// state.
// When the receiver stalls the output register holds its result and the
// sequencer waits before the next element. Reset clears the tables, the step
// sum, the queue and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
module tile_element_delay_quantizer_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // entry_index, offset_x_mm, offset_y_mm, step_delay_ps, dir_l, dir_m
    input  wire logic [tedq_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type
    input  wire logic [1:0]                     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // element, delay_code, chosen_step
    output logic [tedq_pkg::M_TDATA_W-1:0]      m_tdata,
    // was_normalized
    output logic                                m_tuser,
    output logic                                m_tlast
);

    logic           q_full, q_push, q_pop, q_valid;
    tedq_pkg::cmd_t push_cmd, head_cmd;

    tedq_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    tedq_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (head_cmd)
    );

    tedq_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tile_element_delay_quantizer_unit: tile and step
// table loads plus pointing requests, results predicted per element and
// compared in order, with random idling and stalls on both streams.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int LIMIT_CYCLES = 2000000;

    typedef struct {
        logic [3:0] element;
        logic [7:0] code;
        logic [4:0] chosen;
        logic       normed;
        logic       last;
    } elem_delay_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [tedq_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [tedq_pkg::M_TDATA_W-1:0] m_tdata;
    logic m_tuser;
    logic m_tlast;

    longint tile_xs [tedq_pkg::TILE_ELEMENTS];
    longint tile_ys [tedq_pkg::TILE_ELEMENTS];
    longint step_ps [tedq_pkg::DELAY_STEPS];
    logic [19:0] step_total;

    elem_delay_t delay_q[$];
    int errors = 0;
    int hold_off = 0;
    bit calm = 1'b0;
    bit result_taken = 1'b0;
    longint cycles = 0;

    tile_element_delay_quantizer_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    function automatic longint isqrt(input longint v);
        longint res;
        longint t;
        res = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = res | (longint'(1) << b);
            if (t * t <= v)
                res = t;
        end
        return res;
    endfunction

    function automatic longint rescale(input longint v, input longint r);
        longint q;
        q = (((v < 0) ? -v : v) * 32768 + r / 2) / r;
        return (v < 0) ? -q : q;
    endfunction

    function automatic longint absl(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic predict(input logic [1:0] kind, input logic [tedq_pkg::S_TDATA_W-1:0] d);
        logic [4:0] idx;
        longint l, m, sq, r, mean, prod, mag, dly, rough, best, bestdiff, dd;
        bit normed, have;
        elem_delay_t res;
        idx = d[4:0];
        case (kind)
            tedq_pkg::REQ_TILE:
                if (idx < tedq_pkg::TILE_ELEMENTS)
                begin
                    tile_xs[idx] = longint'($signed(d[17:5]));
                    tile_ys[idx] = longint'($signed(d[30:18]));
                end
            tedq_pkg::REQ_STEP:
                if (idx < tedq_pkg::DELAY_STEPS)
                begin
                    step_total = step_total - 20'(step_ps[idx]) + 20'(d[45:31]);
                    step_ps[idx] = longint'(d[45:31]);
                end
            tedq_pkg::REQ_POINT:
            begin
                l = longint'($signed(d[61:46]));
                m = longint'($signed(d[77:62]));
                sq = l * l + m * m;
                normed = 1'b0;
                if (sq > (longint'(1) << 30))
                begin
                    r = isqrt(sq);
                    l = rescale(l, r);
                    m = rescale(m, r);
                    normed = 1'b1;
                end
                mean = longint'(step_total) / tedq_pkg::DELAY_STEPS;
                for (int e = 0; e < tedq_pkg::TILE_ELEMENTS; e++)
                begin
                    prod = (l * tile_xs[e] + m * tile_ys[e]) * 218605;
                    mag = (absl(prod) + (longint'(1) << 30)) >>> 31;
                    dly = ((prod < 0) ? -mag : mag) + mean;
                    rough = dly / 500;
                    best = rough;
                    have = 1'b0;
                    bestdiff = 0;
                    if (rough >= 0 && rough < tedq_pkg::DELAY_STEPS)
                    begin
                        bestdiff = absl(dly - step_ps[rough]);
                        have = 1'b1;
                    end
                    for (longint i = rough - tedq_pkg::SEARCH_RADIUS;
                         i <= rough + tedq_pkg::SEARCH_RADIUS; i++)
                    begin
                        if (i == rough || i < 0 || i >= tedq_pkg::DELAY_STEPS)
                            continue;
                        dd = absl(dly - step_ps[i]);
                        if (!have || dd < bestdiff)
                        begin
                            best = i;
                            bestdiff = dd;
                            have = 1'b1;
                        end
                    end
                    if (best < 0)
                        best = 0;
                    if (best > tedq_pkg::MAX_STEP)
                        best = tedq_pkg::MAX_STEP;
                    res.element = 4'(e);
                    res.code = 8'(best * 4 + 128);
                    res.chosen = 5'(best);
                    res.normed = normed;
                    res.last = (e == tedq_pkg::TILE_ELEMENTS - 1);
                    delay_q.push_back(res);
                end
            end
            default: ;
        endcase
    endtask

    function automatic logic [tedq_pkg::S_TDATA_W-1:0] pack(input logic [4:0] idx,
        input logic [12:0] x, input logic [12:0] y, input logic [14:0] st,
        input logic [15:0] l, input logic [15:0] m);
        return {2'b00, m, l, st, y, x, idx};
    endfunction

    task automatic send_req(input logic [1:0] kind,
        input logic [tedq_pkg::S_TDATA_W-1:0] d);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tuser <= kind;
        s_tdata <= d;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predict(kind, d);
        @(negedge clk);
    endtask

    task automatic send_tile(input int idx, input int x, input int y);
        send_req(tedq_pkg::REQ_TILE, pack(5'(idx), 13'(x), 13'(y), 15'($urandom),
            16'($urandom), 16'($urandom)));
    endtask

    task automatic send_step(input int idx, input int ps);
        send_req(tedq_pkg::REQ_STEP, pack(5'(idx), 13'($urandom), 13'($urandom), 15'(ps),
            16'($urandom), 16'($urandom)));
    endtask

    task automatic send_point(input int l, input int m);
        send_req(tedq_pkg::REQ_POINT, pack(5'($urandom), 13'($urandom), 13'($urandom),
            15'($urandom), 16'(l), 16'(m)));
    endtask

    task automatic test_directed;
        for (int i = 0; i < tedq_pkg::DELAY_STEPS; i += 4)
            send_step(i, i * 500 + 37);
        send_step(31, 32767);
        send_step(0, 0);
        send_tile(0, -4096, 4095);
        send_tile(15, 4095, -4096);
        send_tile(7, 1200, -800);
        send_tile(16, 100, 100);
        send_step(31 + 1, 5);
        send_req(REQ_NONE, pack(5'd3, 13'd5, 13'd5, 15'd5, 16'd5, 16'd5));
        send_point(32767, 0);
        send_point(-32768, -32768);
        send_point(32767, 32767);
        send_point(0, 0);
        send_point(23170, -23170);
        send_point(-32768, 0);
    endtask

    task automatic test_random(input int n);
        int sel;
        int i;
        for (i = 0; i < n; i++)
        begin
            calm = ($urandom_range(0, 9) == 0);
            sel = $urandom_range(0, 19);
            if (sel < 5)
                send_tile($urandom_range(0, 31), $urandom, $urandom);
            else if (sel < 8)
                send_step($urandom_range(0, 31), $urandom);
            else if (sel < 13)
            begin
                sel = $urandom_range(0, 31);
                send_step(sel, sel * 500 + $urandom_range(0, 600) - 300);
            end
            else if (sel < 14)
                send_req(REQ_NONE, {$urandom, $urandom, $urandom});
            else if (sel < 17)
                send_point($urandom_range(0, 46000) - 23000, $urandom_range(0, 46000) - 23000);
            else
                send_point($urandom, $urandom);
        end
        calm = 1'b0;
    endtask

    task automatic test_backpressure;
        hold_off = 800;
        calm = 1'b1;
        for (int i = 0; i < 4; i++)
            send_point($urandom, $urandom);
        calm = 1'b0;
    endtask

    task automatic test_pause;
        send_point($urandom, $urandom);
        s_tvalid <= 1'b0;
        wait (delay_q.size() == 0);
        @(negedge clk);
        send_point($urandom, $urandom);
    endtask

    always
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                m_tready <= 1'b0;
                hold_off--;
            end
            else
            begin
                if (result_taken)
                begin
                    stall = calm ? 0 : $urandom_range(0, 13);
                    result_taken = 1'b0;
                end
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    stall--;
                end
                else
                    m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        elem_delay_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            result_taken = 1'b1;
            if (delay_q.size() == 0)
            begin
                report("unexpected element", m_tdata[3:0], -1);
            end
            else
            begin
                want = delay_q.pop_front();
                if (m_tdata[3:0] != want.element)
                    report("element", m_tdata[3:0], want.element);
                if (m_tdata[11:4] != want.code)
                    report("delay_code", m_tdata[11:4], want.code);
                if (m_tdata[16:12] != want.chosen)
                    report("chosen_step", m_tdata[16:12], want.chosen);
                if (m_tuser != want.normed)
                    report("was_normalized", m_tuser, want.normed);
                if (m_tlast != want.last)
                    report("last", m_tlast, want.last);
            end
        end
    end

    initial
    begin
        for (int i = 0; i < tedq_pkg::TILE_ELEMENTS; i++)
        begin
            tile_xs[i] = 0;
            tile_ys[i] = 0;
        end
        for (int i = 0; i < tedq_pkg::DELAY_STEPS; i++)
            step_ps[i] = 0;
        step_total = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(160);
        test_backpressure();
        test_pause();
        test_random(160);
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (delay_q.size() == 0);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ----- tile_element_delay_quantizer_unit.f -----
src/tedq_pkg.sv
src/tedq_front.sv
src/tedq_queue.sv
src/tedq_back.sv
src/tile_element_delay_quantizer_unit.sv
tb/tb.sv
